// ----- design/bpxh_pkg.sv -----
// Shared types and codes for the board position XOR hash block.
package bpxh_pkg;

  // Field widths of one input item and one result item.
  localparam int COMMAND_W     = 2;
  localparam int KEY_INDEX_W   = 10;
  localparam int KEY_W         = 64;
  localparam int PIECE_W       = 4;
  localparam int SQUARE_W      = 6;
  localparam int CASTLING_W    = 4;
  localparam int EP_SQUARE_W   = 7;
  localparam int FILE_W        = 3;

  // Sizes of the small key stores that follow the piece-square keys.
  localparam int CASTLE_KEYS   = 16;
  localparam int FILE_KEYS     = 8;

  // Depth of the queue between the front and the back.
  localparam int QUEUE_DEPTH   = 4;

  // Command codes carried on the input side.
  localparam logic [COMMAND_W-1:0] CMD_LOAD   = 2'd0;
  localparam logic [COMMAND_W-1:0] CMD_PIECE  = 2'd1;
  localparam logic [COMMAND_W-1:0] CMD_FINISH = 2'd2;

  // Operation kinds decided by the front.
  typedef logic [2:0] kind_t;
  localparam kind_t K_NOP         = 3'd0;
  localparam kind_t K_LOAD_PS     = 3'd1;
  localparam kind_t K_LOAD_CASTLE = 3'd2;
  localparam kind_t K_LOAD_FILE   = 3'd3;
  localparam kind_t K_LOAD_SIDE   = 3'd4;
  localparam kind_t K_PIECE       = 3'd5;
  localparam kind_t K_FINISH      = 3'd6;

  // One classified operation as it travels from the front to the back.
  typedef struct packed {
    kind_t                   kind;
    logic [KEY_INDEX_W-1:0]  key_index;
    logic [KEY_W-1:0]        key_value;
    logic [PIECE_W-1:0]      piece;
    logic [SQUARE_W-1:0]     square;
    logic [CASTLING_W-1:0]   castling;
    logic                    ep_valid;
    logic [FILE_W-1:0]       ep_file;
    logic                    white_to_move;
    logic [CASTLING_W-1:0]   slot;
  } op_t;

  // Status of the back's second stage, watched by the top level.
  typedef struct packed {
    logic  s2_valid;
    kind_t s2_kind;
    logic  s2_go;
    logic  acc_zero;
  } back_stat_t;

endpackage

// ----- design/board_position_xor_hash.sv -----
// Top level of the board position XOR hash block.
//
// Usage: items arrive on the s_ channel. s_tuser holds the command: load a key,
// XOR one piece-square key into the running hash, or finish. A finish item adds
// the castling key, the en-passant file key if any and the side key when black
// moves, sends the 64-bit hash out on the m_ channel and clears the running hash.
// Load and piece items, and items with an unused command, send nothing.
// Keys must be loaded before any item reads them; the key store is not cleared.
// A finish item passes the front register, the queue, the key read stage and
// the XOR stage into the output register. Throughput: one item per cycle of
// any kind unless a finish waits on a full output register, set by the
// single-port key memory serving one load write or one piece read each cycle.
// Reset clears the running hash, the queue and all valid flags.
// When the receiver holds m_tready low, the result stays in the output register;
// loads and pieces behind it keep flowing until the next finish reaches the XOR
// stage, then the queue fills and s_tready drops.
module board_position_xor_hash #(
  parameter int PIECE_KINDS   = 12,
  parameter int BOARD_SQUARES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // key_index[9:0], key_value[73:10], piece[77:74], square[83:78],
  // castling[87:84], ep_square[94:88], white_to_move[95]
  input  logic [95:0] s_tdata,
  // command[1:0]
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // hash[63:0]
  output logic [63:0] m_tdata
);

  logic                 push;
  bpxh_pkg::op_t        push_op;
  logic                 queue_full;
  logic                 pop;
  logic                 head_valid;
  bpxh_pkg::op_t        head_op;
  bpxh_pkg::back_stat_t stat;

  // Front: accept and classify.
  bpxh_front #(
    .PIECE_KINDS   (PIECE_KINDS),
    .BOARD_SQUARES (BOARD_SQUARES)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s_tvalid),
    .in_ready      (s_tready),
    .command       (s_tuser),
    .key_index     (s_tdata[9:0]),
    .key_value     (s_tdata[73:10]),
    .piece         (s_tdata[77:74]),
    .square        (s_tdata[83:78]),
    .castling      (s_tdata[87:84]),
    .ep_square     (s_tdata[94:88]),
    .white_to_move (s_tdata[95]),
    .push          (push),
    .push_op       (push_op),
    .queue_full    (queue_full)
  );

  // Queue between front and back.
  bpxh_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_op    (push_op),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_op    (head_op)
  );

  // Back: key stores, hash pipeline and output register.
  bpxh_back #(
    .PIECE_KINDS   (PIECE_KINDS),
    .BOARD_SQUARES (BOARD_SQUARES)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_op    (head_op),
    .pop        (pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_hash   (m_tdata),
    .stat       (stat)
  );

  // A new result only ever comes from a finish leaving the XOR stage.
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(stat.s2_valid && (stat.s2_kind == bpxh_pkg::K_FINISH)))
    else $error("result appeared without a finish in the XOR stage");

  // A finish waiting on a full output register stays in the XOR stage.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready && stat.s2_valid && (stat.s2_kind == bpxh_pkg::K_FINISH))
    |=> (stat.s2_valid && (stat.s2_kind == bpxh_pkg::K_FINISH)))
    else $error("finish left the XOR stage while the output was stalled");

  // The running hash starts from zero after every finish.
  assert property (@(posedge clk) disable iff (rst)
    (stat.s2_valid && stat.s2_go && (stat.s2_kind == bpxh_pkg::K_FINISH))
    |=> stat.acc_zero)
    else $error("running hash not cleared after a finish");

endmodule

// ----- design/bpxh_front.sv -----
// Front part: accepts input items, range checks them and classifies them into operations.
module bpxh_front #(
  parameter int PIECE_KINDS   = 12,
  parameter int BOARD_SQUARES = 64
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [bpxh_pkg::COMMAND_W-1:0]         command,
  input  logic [bpxh_pkg::KEY_INDEX_W-1:0]       key_index,
  input  logic [bpxh_pkg::KEY_W-1:0]             key_value,
  input  logic [bpxh_pkg::PIECE_W-1:0]           piece,
  input  logic [bpxh_pkg::SQUARE_W-1:0]          square,
  input  logic [bpxh_pkg::CASTLING_W-1:0]        castling,
  input  logic signed [bpxh_pkg::EP_SQUARE_W-1:0] ep_square,
  input  logic                                   white_to_move,
  output logic                                   push,
  output bpxh_pkg::op_t                          push_op,
  input  logic                                   queue_full
);

  localparam int PIECE_KEYS  = PIECE_KINDS * BOARD_SQUARES;
  localparam int CASTLE_BASE = PIECE_KEYS;
  localparam int FILE_BASE   = CASTLE_BASE + bpxh_pkg::CASTLE_KEYS;
  localparam int SIDE_SLOT   = FILE_BASE + bpxh_pkg::FILE_KEYS;
  localparam int IDX_RAW     = $clog2(SIDE_SLOT + 2);
  localparam int IW          = (IDX_RAW > bpxh_pkg::KEY_INDEX_W) ? IDX_RAW
                                                                 : bpxh_pkg::KEY_INDEX_W;

  logic          held_valid;
  bpxh_pkg::op_t held_op;
  bpxh_pkg::op_t op_next;
  logic [IW-1:0] ki;
  logic [IW-1:0] ki_off;

  // The holding register frees up whenever its operation moves into the queue.
  assign push     = held_valid && !queue_full;
  assign in_ready = !held_valid || !queue_full;
  assign push_op  = held_op;

  assign ki = IW'(key_index);

  // Classify the incoming item.
  always_comb begin
    ki_off                = ki - IW'(CASTLE_BASE);
    op_next               = '0;
    op_next.kind          = bpxh_pkg::K_NOP;
    op_next.key_index     = key_index;
    op_next.key_value     = key_value;
    op_next.piece         = piece;
    op_next.square        = square;
    op_next.castling      = castling;
    op_next.white_to_move = white_to_move;
    op_next.ep_file       = ep_square[bpxh_pkg::FILE_W-1:0];
    op_next.ep_valid      = !ep_square[bpxh_pkg::EP_SQUARE_W-1] &&
                            (32'(ep_square[bpxh_pkg::EP_SQUARE_W-2:0]) < BOARD_SQUARES);
    op_next.slot          = ki_off[bpxh_pkg::CASTLING_W-1:0];
    case (command)
      bpxh_pkg::CMD_LOAD: begin
        if (ki < IW'(CASTLE_BASE)) begin
          op_next.kind = bpxh_pkg::K_LOAD_PS;
        end else if (ki < IW'(FILE_BASE)) begin
          op_next.kind = bpxh_pkg::K_LOAD_CASTLE;
        end else if (ki < IW'(SIDE_SLOT)) begin
          op_next.kind = bpxh_pkg::K_LOAD_FILE;
        end else if (ki == IW'(SIDE_SLOT)) begin
          op_next.kind = bpxh_pkg::K_LOAD_SIDE;
        end
      end
      bpxh_pkg::CMD_PIECE: begin
        if ((32'(piece) < PIECE_KINDS) && (32'(square) < BOARD_SQUARES)) begin
          op_next.kind = bpxh_pkg::K_PIECE;
        end
      end
      bpxh_pkg::CMD_FINISH: begin
        op_next.kind = bpxh_pkg::K_FINISH;
      end
      default: begin
        op_next.kind = bpxh_pkg::K_NOP;
      end
    endcase
  end

  // Holding register control.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      held_valid <= 1'b1;
    end else if (push) begin
      held_valid <= 1'b0;
    end
  end

  // Holding register payload.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_op <= op_next;
    end
  end

endmodule

// ----- design/bpxh_queue.sv -----
// Short operation queue that decouples the front from the back.
module bpxh_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  bpxh_pkg::op_t push_op,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output bpxh_pkg::op_t head_op
);

  localparam int PW = $clog2(bpxh_pkg::QUEUE_DEPTH);
  localparam int CW = $clog2(bpxh_pkg::QUEUE_DEPTH + 1);

  bpxh_pkg::op_t entries [bpxh_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full       = (count == CW'(bpxh_pkg::QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_op    = entries[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_op;
    end
  end

endmodule

// ----- design/bpxh_back.sv -----
// Back part: key stores, the two-stage read and XOR pipeline and the output register.
module bpxh_back #(
  parameter int PIECE_KINDS   = 12,
  parameter int BOARD_SQUARES = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        head_valid,
  input  bpxh_pkg::op_t               head_op,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [bpxh_pkg::KEY_W-1:0]  out_hash,
  output bpxh_pkg::back_stat_t        stat
);

  localparam int PIECE_KEYS = PIECE_KINDS * BOARD_SQUARES;
  localparam int AW         = $clog2(PIECE_KEYS);

  logic [bpxh_pkg::KEY_W-1:0] ps_mem      [PIECE_KEYS];
  logic [bpxh_pkg::KEY_W-1:0] castle_keys [bpxh_pkg::CASTLE_KEYS];
  logic [bpxh_pkg::KEY_W-1:0] file_keys   [bpxh_pkg::FILE_KEYS];
  logic [bpxh_pkg::KEY_W-1:0] side_key;

  logic                       s2_valid;
  bpxh_pkg::kind_t            s2_kind;
  logic [bpxh_pkg::KEY_W-1:0] rdata;
  logic [bpxh_pkg::KEY_W-1:0] extra;
  logic [bpxh_pkg::KEY_W-1:0] acc;
  logic                       s2_go;
  logic                       advance;
  logic                       s2_finish;
  logic [AW-1:0]              wr_addr;
  logic [AW-1:0]              rd_addr;

  // Stage two stalls only when it holds a finish and the output register is still full.
  assign s2_go     = (s2_kind != bpxh_pkg::K_FINISH) || !out_valid || out_ready;
  assign advance   = !s2_valid || s2_go;
  assign pop       = head_valid && advance;
  assign s2_finish = s2_valid && s2_go && (s2_kind == bpxh_pkg::K_FINISH);

  assign wr_addr = AW'(head_op.key_index);
  assign rd_addr = AW'(32'(head_op.piece) * BOARD_SQUARES + 32'(head_op.square));

  assign stat.s2_valid = s2_valid;
  assign stat.s2_kind  = s2_kind;
  assign stat.s2_go    = s2_go;
  assign stat.acc_zero = (acc == '0);

  // Piece-square key memory: one write or one registered read per cycle.
  always_ff @(posedge clk) begin
    if (pop && (head_op.kind == bpxh_pkg::K_LOAD_PS)) begin
      ps_mem[wr_addr] <= head_op.key_value;
    end
    if (pop && (head_op.kind == bpxh_pkg::K_PIECE)) begin
      rdata <= ps_mem[rd_addr];
    end
  end

  // Castling, file and side keys live in registers.
  always_ff @(posedge clk) begin
    if (pop) begin
      case (head_op.kind)
        bpxh_pkg::K_LOAD_CASTLE: castle_keys[head_op.slot] <= head_op.key_value;
        bpxh_pkg::K_LOAD_FILE:   file_keys[head_op.slot[bpxh_pkg::FILE_W-1:0]] <=
                                   head_op.key_value;
        bpxh_pkg::K_LOAD_SIDE:   side_key <= head_op.key_value;
        default: begin
        end
      endcase
    end
  end

  // A finish gathers its castling, file and side keys in stage one.
  always_ff @(posedge clk) begin
    if (pop && (head_op.kind == bpxh_pkg::K_FINISH)) begin
      extra <= castle_keys[head_op.castling] ^
               (head_op.ep_valid ? file_keys[head_op.ep_file] : '0) ^
               (head_op.white_to_move ? '0 : side_key);
    end
  end

  // Stage two control, accumulator and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid  <= 1'b0;
      s2_kind   <= bpxh_pkg::K_NOP;
      acc       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        s2_valid <= pop;
        s2_kind  <= head_op.kind;
      end
      if (s2_valid && s2_go && (s2_kind == bpxh_pkg::K_PIECE)) begin
        acc <= acc ^ rdata;
      end else if (s2_finish) begin
        acc <= '0;
      end
      if (s2_finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output payload.
  always_ff @(posedge clk) begin
    if (s2_finish) begin
      out_hash <= acc ^ extra;
    end
  end

endmodule
